### hdl/aec_pkg.sv
package aec_pkg;

  localparam int ADDR_W = 5;

  typedef enum logic [2:0] {
    REG_B0,
    REG_B1,
    REG_B2,
    REG_A1,
    REG_A2,
    REG_DIST,
    REG_DECIM,
    REG_CRUSH
  } aec_reg_t;

  localparam logic [31:0] B0_RESET    = 32'd268435456;
  localparam logic [4:0]  CRUSH_RESET = 5'd16;
  localparam logic [4:0]  CRUSH_MIN   = 5'd4;
  localparam logic [4:0]  CRUSH_FULL  = 5'd16;

  // distortion constants
  localparam logic [6:0]  PCT_MAX   = 7'd100;
  localparam logic [8:0]  GAIN_BASE = 9'd100;
  localparam logic [8:0]  GAIN_STEP = 9'd3;
  localparam int          KNEE      = 29491;
  localparam int          KNEE_X100 = 2949100;
  localparam int          DIST_N_W  = 24;
  localparam int          DIST_Q_W  = 15;

  // n / 1000 and n / 100 by reciprocal, then one correction step
  localparam logic [9:0]  DIV_HI    = 10'd1000;
  localparam logic [9:0]  DIV_LO    = 10'd100;
  localparam logic [31:0] RECIP_HI  = 32'd17179869;
  localparam logic [31:0] RECIP_LO  = 32'd10737418;
  localparam int          SHIFT_HI  = 34;
  localparam int          SHIFT_LO  = 30;

  typedef struct packed {
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic signed [31:0] b2;
    logic signed [31:0] a1;
    logic signed [31:0] a2;
    logic [6:0]         dist_pct;
    logic [3:0]         decim;
    logic [4:0]         crush_bits;
  } aec_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIST_MUL,
    ST_DIST_DIV,
    ST_DIST_FIX,
    ST_B0,
    ST_B1,
    ST_A1,
    ST_B2,
    ST_A2,
    ST_FINISH
  } aec_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_DIST_MUL,
    OP_DIST_DIV,
    OP_DIST_FIX,
    OP_B0,
    OP_B1,
    OP_A1,
    OP_B2,
    OP_A2,
    OP_FINISH
  } aec_op_t;

  typedef struct packed {
    logic    load_in;
    aec_op_t op;
  } aec_cmd_t;

  typedef struct packed {
    logic out_busy;
    logic bypass;
  } aec_status_t;

endpackage

### hdl/aec_regs.sv
module aec_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output aec_pkg::aec_cfg_t          cfg,
  output logic                       dec_clear
);

  logic                wr;
  aec_pkg::aec_reg_t   idx;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign idx       = aec_pkg::aec_reg_t'(paddr[aec_pkg::ADDR_W-1:2]);
  assign dec_clear = wr && (idx == aec_pkg::REG_DECIM);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.b0         <= aec_pkg::B0_RESET;
      cfg.b1         <= '0;
      cfg.b2         <= '0;
      cfg.a1         <= '0;
      cfg.a2         <= '0;
      cfg.dist_pct   <= '0;
      cfg.decim      <= '0;
      cfg.crush_bits <= aec_pkg::CRUSH_RESET;
    end else if (wr) begin
      case (idx)
        aec_pkg::REG_B0:    cfg.b0         <= pwdata;
        aec_pkg::REG_B1:    cfg.b1         <= pwdata;
        aec_pkg::REG_B2:    cfg.b2         <= pwdata;
        aec_pkg::REG_A1:    cfg.a1         <= pwdata;
        aec_pkg::REG_A2:    cfg.a2         <= pwdata;
        aec_pkg::REG_DIST:  cfg.dist_pct   <= pwdata[6:0];
        aec_pkg::REG_DECIM: cfg.decim      <= pwdata[3:0];
        aec_pkg::REG_CRUSH: cfg.crush_bits <= pwdata[4:0];
        default:            cfg.b0         <= cfg.b0;
      endcase
    end
  end

  always_comb begin
    case (idx)
      aec_pkg::REG_B0:    prdata = cfg.b0;
      aec_pkg::REG_B1:    prdata = cfg.b1;
      aec_pkg::REG_B2:    prdata = cfg.b2;
      aec_pkg::REG_A1:    prdata = cfg.a1;
      aec_pkg::REG_A2:    prdata = cfg.a2;
      aec_pkg::REG_DIST:  prdata = {25'd0, cfg.dist_pct};
      aec_pkg::REG_DECIM: prdata = {28'd0, cfg.decim};
      aec_pkg::REG_CRUSH: prdata = {27'd0, cfg.crush_bits};
      default:            prdata = '0;
    endcase
  end

endmodule

### hdl/aec_ctrl.sv
module aec_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_in_valid,
  output logic                 sample_in_stall,
  input  aec_pkg::aec_status_t status,
  output aec_pkg::aec_cmd_t    cmd
);

  aec_pkg::aec_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= aec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign sample_in_stall = (state != aec_pkg::ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.load_in = 1'b0;
    cmd.op      = aec_pkg::OP_NONE;
    case (state)
      aec_pkg::ST_IDLE: begin
        if (sample_in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = aec_pkg::ST_DIST_MUL;
        end
      end
      aec_pkg::ST_DIST_MUL: begin
        cmd.op     = aec_pkg::OP_DIST_MUL;
        state_next = aec_pkg::ST_DIST_DIV;
      end
      aec_pkg::ST_DIST_DIV: begin
        cmd.op     = aec_pkg::OP_DIST_DIV;
        state_next = aec_pkg::ST_DIST_FIX;
      end
      aec_pkg::ST_DIST_FIX: begin
        cmd.op     = aec_pkg::OP_DIST_FIX;
        state_next = status.bypass ? aec_pkg::ST_FINISH : aec_pkg::ST_B0;
      end
      aec_pkg::ST_B0: begin
        cmd.op     = aec_pkg::OP_B0;
        state_next = aec_pkg::ST_B1;
      end
      aec_pkg::ST_B1: begin
        cmd.op     = aec_pkg::OP_B1;
        state_next = aec_pkg::ST_A1;
      end
      aec_pkg::ST_A1: begin
        cmd.op     = aec_pkg::OP_A1;
        state_next = aec_pkg::ST_B2;
      end
      aec_pkg::ST_B2: begin
        cmd.op     = aec_pkg::OP_B2;
        state_next = aec_pkg::ST_A2;
      end
      aec_pkg::ST_A2: begin
        cmd.op     = aec_pkg::OP_A2;
        state_next = aec_pkg::ST_FINISH;
      end
      aec_pkg::ST_FINISH: begin
        if (!status.out_busy) begin
          cmd.op     = aec_pkg::OP_FINISH;
          state_next = aec_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = aec_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### hdl/aec_dp.sv
module aec_dp #(
  parameter int COEF_FRAC_BITS  = 28,
  parameter int STATE_FRAC_BITS = 12
) (
  input  logic                 clk,
  input  logic                 rst,
  input  aec_pkg::aec_cfg_t    cfg,
  input  logic                 dec_clear,
  input  aec_pkg::aec_cmd_t    cmd,
  output aec_pkg::aec_status_t status,
  input  logic signed [15:0]   sample_in,
  output logic signed [15:0]   sample_out,
  output logic                 sample_out_valid,
  input  logic                 sample_out_stall
);

  localparam int NW    = aec_pkg::DIST_N_W;
  localparam int QW    = aec_pkg::DIST_Q_W;
  localparam int YW    = 16 + STATE_FRAC_BITS;
  localparam int MB_W  = (YW > NW + 1) ? YW : NW + 1;
  localparam int PW    = 32 + MB_W;
  localparam int SH    = COEF_FRAC_BITS - STATE_FRAC_BITS;
  localparam int SHR   = (SH > 0) ? SH : 0;
  localparam int SHL   = (SH < 0) ? -SH : 0;
  localparam int ACC_W = PW + SHL + 2;

  localparam logic signed [ACC_W-1:0] Y_HI   = (ACC_W'(1) <<< (YW - 1)) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] Y_LO   = -(ACC_W'(1) <<< (YW - 1));
  localparam logic signed [ACC_W-1:0] S48_HI = (ACC_W'(1) <<< 47) - ACC_W'(1);
  localparam logic signed [ACC_W-1:0] S48_LO = -(ACC_W'(1) <<< 47);
  localparam logic signed [25:0]      THR    = 26'(aec_pkg::KNEE_X100);
  localparam logic [31:0]             UNITY  = 32'(64'd1 << COEF_FRAC_BITS);

  // registers
  logic signed [15:0]       x;
  logic [NW-1:0]            n;
  logic                     neg;
  logic                     knee;
  logic [QW-1:0]            q;
  logic signed [15:0]       xd;
  logic signed [YW-1:0]     y;
  logic signed [ACC_W-1:0]  acc;
  logic signed [47:0]       s1;
  logic signed [47:0]       s2;
  logic signed [15:0]       held;
  logic [3:0]               hcnt;

  // shared multiplier
  logic signed [31:0]       mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PW-1:0]     prod;
  logic signed [ACC_W-1:0]  prod_w;
  logic signed [ACC_W-1:0]  t_x;
  logic signed [ACC_W-1:0]  t_y;

  // distortion
  logic [6:0]               pct;
  logic [8:0]               gain;
  logic signed [25:0]       v;
  logic [NW-1:0]            n_next;
  logic                     knee_next;
  logic [QW-1:0]            q_est;
  logic [9:0]               dvs;
  logic [NW:0]              qd;
  logic [NW:0]              rem;
  logic [QW-1:0]            q_fix;
  logic [15:0]              mag;
  logic signed [15:0]       dist_res;

  // filter
  logic signed [ACC_W-1:0]  y_sum;
  logic signed [ACC_W-1:0]  y_sat;
  logic signed [ACC_W-1:0]  s_sum;
  logic signed [ACC_W-1:0]  s_sat;
  logic                     y_neg;
  logic [YW:0]              y_mag;
  logic [16:0]              y_q;
  logic signed [15:0]       filt_y;
  logic signed [15:0]       filt;

  // decimator and crusher
  logic                     refresh;
  logic signed [15:0]       dec_out;
  logic [4:0]               cb;
  logic [3:0]               csh;
  logic signed [15:0]       crushed;

  assign status.bypass   = (cfg.b0 == UNITY) && (cfg.b1 == '0) && (cfg.b2 == '0) &&
                           (cfg.a1 == '0) && (cfg.a2 == '0);
  assign status.out_busy = sample_out_valid && sample_out_stall;

  assign pct  = (cfg.dist_pct > aec_pkg::PCT_MAX) ? aec_pkg::PCT_MAX : cfg.dist_pct;
  assign gain = aec_pkg::GAIN_BASE + 9'(pct) * aec_pkg::GAIN_STEP;

  always_comb begin
    case (cmd.op)
      aec_pkg::OP_DIST_MUL: begin
        mul_a = 32'(gain);
        mul_b = MB_W'(x);
      end
      aec_pkg::OP_DIST_DIV: begin
        mul_a = knee ? aec_pkg::RECIP_HI : aec_pkg::RECIP_LO;
        mul_b = MB_W'(n);
      end
      aec_pkg::OP_B0: begin
        mul_a = cfg.b0;
        mul_b = MB_W'(xd);
      end
      aec_pkg::OP_B1: begin
        mul_a = cfg.b1;
        mul_b = MB_W'(xd);
      end
      aec_pkg::OP_A1: begin
        mul_a = cfg.a1;
        mul_b = MB_W'(y);
      end
      aec_pkg::OP_B2: begin
        mul_a = cfg.b2;
        mul_b = MB_W'(xd);
      end
      aec_pkg::OP_A2: begin
        mul_a = cfg.a2;
        mul_b = MB_W'(y);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_w = ACC_W'(prod);
  assign t_x    = (prod_w >>> SHR) <<< SHL;
  assign t_y    = prod_w >>> COEF_FRAC_BITS;

  // distortion: split into knee or linear part, divide by reciprocal
  assign v = prod[25:0];

  always_comb begin
    if (v > THR) begin
      knee_next = 1'b1;
      n_next    = NW'(v - THR);
    end else if (v < -THR) begin
      knee_next = 1'b1;
      n_next    = NW'(-THR - v);
    end else begin
      knee_next = 1'b0;
      n_next    = v[25] ? NW'(-v) : NW'(v);
    end
  end

  assign q_est = knee ? prod[aec_pkg::SHIFT_HI +: QW] : prod[aec_pkg::SHIFT_LO +: QW];
  assign dvs   = knee ? aec_pkg::DIV_HI : aec_pkg::DIV_LO;
  assign qd    = (NW + 1)'(q) * (NW + 1)'(dvs);
  assign rem   = (NW + 1)'(n) - qd;
  assign q_fix = (rem >= (NW + 1)'(dvs)) ? q + QW'(1) : q;
  assign mag   = knee ? 16'(aec_pkg::KNEE) + 16'(q_fix) : 16'(q_fix);

  always_comb begin
    if (pct == '0) begin
      dist_res = x;
    end else if (!neg) begin
      dist_res = (mag > 16'd32767) ? 16'sd32767 : $signed(mag);
    end else begin
      dist_res = (mag > 16'd32768) ? -16'sd32768 : $signed(16'd0 - mag);
    end
  end

  // biquad, transposed direct form II
  assign y_sum = t_x + ACC_W'(s1);
  assign y_sat = (y_sum > Y_HI) ? Y_HI : ((y_sum < Y_LO) ? Y_LO : y_sum);

  always_comb begin
    if (cmd.op == aec_pkg::OP_B2) begin
      s_sum = t_x;
    end else begin
      s_sum = acc - t_y;
    end
  end

  assign s_sat = (s_sum > S48_HI) ? S48_HI : ((s_sum < S48_LO) ? S48_LO : s_sum);

  // truncate toward zero back to sample precision
  assign y_neg  = y[YW-1];
  assign y_mag  = y_neg ? (YW + 1)'(-((YW + 1)'(y))) : (YW + 1)'(y);
  assign y_q    = 17'(y_mag >> STATE_FRAC_BITS);
  assign filt_y = y_neg ? 16'(17'd0 - y_q) : 16'(y_q);
  assign filt   = status.bypass ? xd : filt_y;

  assign refresh = (cfg.decim != '0) && (hcnt >= cfg.decim);
  assign dec_out = (cfg.decim == '0) ? filt : (refresh ? filt : held);

  assign cb  = (cfg.crush_bits < aec_pkg::CRUSH_MIN) ? aec_pkg::CRUSH_MIN : cfg.crush_bits;
  assign csh = 4'(aec_pkg::CRUSH_FULL - cb);

  always_comb begin
    if (cb >= aec_pkg::CRUSH_FULL) begin
      crushed = dec_out;
    end else begin
      crushed = dec_out & (16'hFFFF << csh);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      x <= sample_in;
    end
    case (cmd.op)
      aec_pkg::OP_DIST_MUL: begin
        n    <= n_next;
        knee <= knee_next;
        neg  <= v[25];
      end
      aec_pkg::OP_DIST_DIV: q   <= q_est;
      aec_pkg::OP_DIST_FIX: xd  <= dist_res;
      aec_pkg::OP_B0:       y   <= YW'(y_sat);
      aec_pkg::OP_B1:       acc <= t_x + ACC_W'(s2);
      aec_pkg::OP_B2:       acc <= s_sum;
      default:              acc <= acc;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1               <= '0;
      s2               <= '0;
      held             <= '0;
      hcnt             <= '0;
      sample_out_valid <= 1'b0;
    end else begin
      if (cmd.op == aec_pkg::OP_A1) begin
        s1 <= 48'(s_sat);
      end
      if (cmd.op == aec_pkg::OP_A2) begin
        s2 <= 48'(s_sat);
      end
      if (dec_clear) begin
        hcnt <= '0;
      end else if (cmd.op == aec_pkg::OP_FINISH && cfg.decim != '0) begin
        if (refresh) begin
          held <= filt;
          hcnt <= '0;
        end else begin
          hcnt <= hcnt + 4'd1;
        end
      end
      if (cmd.op == aec_pkg::OP_FINISH) begin
        sample_out_valid <= 1'b1;
      end else if (!sample_out_stall) begin
        sample_out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == aec_pkg::OP_FINISH) begin
      sample_out <= crushed;
    end
  end

endmodule

### hdl/audio_effects_chain.sv
// channel     | handshake                         | payload
// ------------+-----------------------------------+----------------------
// sample in   | sample_in_valid / sample_in_stall | sample_in  s16
// sample out  | sample_out_valid / sample_out_stall | sample_out s16
// config      | APB write/read, psel penable      | paddr pwdata prdata
//
// A sample passes the distortion steps and, with the filter active, the filter
// steps before the next acceptance; bypass skips the filter steps. The shared
// multiplier does two distortion products and five filter products, one a cycle.
// rst is synchronous; it restores register defaults and clears filter state,
// the held sample, the hold counter and the output valid flag.
// A finished sample waits in the output register under sample_out_stall while
// the next sample is taken in; the last step waits for that register to free.
module audio_effects_chain #(
  parameter int COEF_FRAC_BITS  = 28,
  parameter int STATE_FRAC_BITS = 12
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [aec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic signed [15:0]         sample_in,
  input  logic                       sample_in_valid,
  output logic                       sample_in_stall,
  output logic signed [15:0]         sample_out,
  output logic                       sample_out_valid,
  input  logic                       sample_out_stall
);

  aec_pkg::aec_cfg_t    cfg;
  logic                 dec_clear;
  aec_pkg::aec_cmd_t    cmd;
  aec_pkg::aec_status_t status;

  aec_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cfg       (cfg),
    .dec_clear (dec_clear)
  );

  aec_ctrl u_ctrl (
    .clk             (clk),
    .rst             (rst),
    .sample_in_valid (sample_in_valid),
    .sample_in_stall (sample_in_stall),
    .status          (status),
    .cmd             (cmd)
  );

  aec_dp #(
    .COEF_FRAC_BITS  (COEF_FRAC_BITS),
    .STATE_FRAC_BITS (STATE_FRAC_BITS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .dec_clear        (dec_clear),
    .cmd              (cmd),
    .status           (status),
    .sample_in        (sample_in),
    .sample_out       (sample_out),
    .sample_out_valid (sample_out_valid),
    .sample_out_stall (sample_out_stall)
  );

endmodule
